FILE: hdl/gcd_pkg.sv
// Shared types, constants and the chunk-size table of the guided chunk dispenser.
// Depends on nothing; every other file of the block uses it by scoped name.
package gcd_pkg;

  localparam int JOB_W   = 31;
  localparam int SUM_W   = 32;
  localparam int CHUNK_W = 11;
  localparam int REQ_W   = 10;
  localparam int THR_W   = 9;
  localparam int WRK_W   = 10;
  localparam int PROF_W  = 2;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = 3;

  localparam logic [JOB_W-1:0]   JOB_MAX     = '1;
  localparam logic [CHUNK_W-1:0] THREADS_MAX = 11'd256;
  localparam int                 TABLE_TOP   = 3;

  // Register indexes (byte address / 4)
  localparam logic [IDX_W-1:0] REG_PROFILE = 3'd0;
  localparam logic [IDX_W-1:0] REG_START   = 3'd1;
  localparam logic [IDX_W-1:0] REG_JOBS    = 3'd2;
  localparam logic [IDX_W-1:0] REG_THREADS = 3'd3;
  localparam logic [IDX_W-1:0] REG_WORKERS = 3'd4;

  // Profile codes; the unused code behaves as PROF_THREE
  localparam logic [PROF_W-1:0] PROF_THREE = 2'd0;
  localparam logic [PROF_W-1:0] PROF_TWO   = 2'd1;
  localparam logic [PROF_W-1:0] PROF_FOUR  = 2'd2;

  typedef struct packed {
    logic               busy;     // derived values or state not yet loaded
    logic               reload;   // load start value and first level now
    logic [JOB_W-1:0]   start;
    logic [SUM_W-1:0]   last;
    logic [WRK_W-1:0]   workers;
  } cfg_ctl_t;

  function automatic logic [CHUNK_W-1:0] chunk_of(logic [PROF_W-1:0] prof,
                                                  logic [THR_W-1:0] thr,
                                                  int lvl);
    logic [CHUNK_W-1:0] t;
    logic [CHUNK_W-1:0] half;
    logic [CHUNK_W-1:0] quarter;
    logic [CHUNK_W-1:0] c;
    int                 l;
    if (thr == '0) begin
      t = CHUNK_W'(1);
    end else if (CHUNK_W'(thr) > THREADS_MAX) begin
      t = THREADS_MAX;
    end else begin
      t = CHUNK_W'(thr);
    end
    half    = t >> 1;
    quarter = t >> 2;
    l = (lvl > TABLE_TOP) ? TABLE_TOP : lvl;
    if (prof == PROF_TWO || prof == PROF_FOUR) begin
      case (l)
        0:       c = (prof == PROF_TWO) ? (t << 1) + t : (t << 2);
        1:       c = t << 1;
        2:       c = t;
        default: c = (half == '0) ? CHUNK_W'(1) : half;
      endcase
    end else begin
      case (l)
        0:       c = t << 1;
        1:       c = t;
        2:       c = (half < CHUNK_W'(2)) ? CHUNK_W'(2) : half;
        default: c = (quarter == '0) ? CHUNK_W'(1) : quarter;
      endcase
    end
    return c;
  endfunction

endpackage

FILE: hdl/gcd_if.sv
// Valid/ready request and reply channels of the guided chunk dispenser.
// Depends on gcd_pkg for field widths.
interface gcd_req_if;
  logic                      valid;
  logic                      ready;
  logic [gcd_pkg::REQ_W-1:0] requester;

  modport source (output valid, output requester, input ready);
  modport sink   (input valid, input requester, output ready);
endinterface

interface gcd_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [gcd_pkg::REQ_W-1:0]   destination;
  logic [gcd_pkg::JOB_W-1:0]   first_job;
  logic [gcd_pkg::CHUNK_W-1:0] chunk_size;
  logic                        range_exhausted;
  logic                        all_done;

  modport source (output valid, output destination, output first_job, output chunk_size,
                  output range_exhausted, output all_done, input ready);
  modport sink   (input valid, input destination, input first_job, input chunk_size,
                  input range_exhausted, input all_done, output ready);
endinterface

FILE: hdl/gcd_cfg.sv
// APB register file plus registered chunk sizes for every level and limits for all but the top.
// Depends on gcd_pkg.
module gcd_cfg #(
  parameter int LEVELS = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gcd_pkg::ADDR_W-1:0]    paddr,
  input  logic [gcd_pkg::DATA_W-1:0]    pwdata,
  output logic [gcd_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output gcd_pkg::cfg_ctl_t             ctl,
  output logic [gcd_pkg::SUM_W-1:0]     lim [LEVELS-1],
  output logic [gcd_pkg::CHUNK_W-1:0]   chunk [LEVELS]
);

  logic [gcd_pkg::PROF_W-1:0] profile;
  logic [gcd_pkg::JOB_W-1:0]  start_value;
  logic [gcd_pkg::JOB_W-1:0]  job_count;
  logic [gcd_pkg::THR_W-1:0]  thread_count;
  logic [gcd_pkg::WRK_W-1:0]  worker_count;
  logic [1:0]                 init_cnt;
  logic [gcd_pkg::SUM_W-1:0]  last;
  logic [gcd_pkg::IDX_W-1:0]  idx;
  logic                       wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[gcd_pkg::ADDR_W-1:2];

  // Register writes; a write to a listed register restarts the load sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      profile      <= gcd_pkg::PROF_THREE;
      start_value  <= '0;
      job_count    <= '0;
      thread_count <= gcd_pkg::THR_W'(1);
      worker_count <= gcd_pkg::WRK_W'(1);
      init_cnt     <= 2'd2;
    end else begin
      if (wr) begin
        unique case (idx)
          gcd_pkg::REG_PROFILE: profile      <= pwdata[gcd_pkg::PROF_W-1:0];
          gcd_pkg::REG_START:   start_value  <= pwdata[gcd_pkg::JOB_W-1:0];
          gcd_pkg::REG_JOBS:    job_count    <= pwdata[gcd_pkg::JOB_W-1:0];
          gcd_pkg::REG_THREADS: thread_count <= pwdata[gcd_pkg::THR_W-1:0];
          gcd_pkg::REG_WORKERS: worker_count <= pwdata[gcd_pkg::WRK_W-1:0];
          default: ;
        endcase
      end
      if (wr && idx <= gcd_pkg::REG_WORKERS) begin
        init_cnt <= 2'd2;
      end else if (init_cnt != 2'd0) begin
        init_cnt <= init_cnt - 2'd1;
      end
    end
  end

  always_comb begin
    unique case (idx)
      gcd_pkg::REG_PROFILE: prdata = gcd_pkg::DATA_W'(profile);
      gcd_pkg::REG_START:   prdata = gcd_pkg::DATA_W'(start_value);
      gcd_pkg::REG_JOBS:    prdata = gcd_pkg::DATA_W'(job_count);
      gcd_pkg::REG_THREADS: prdata = gcd_pkg::DATA_W'(thread_count);
      gcd_pkg::REG_WORKERS: prdata = gcd_pkg::DATA_W'(worker_count);
      default:              prdata = '0;
    endcase
  end

  // Derived values are registered from the registers and follow them in the next cycle
  always_ff @(posedge clk) begin
    last <= gcd_pkg::SUM_W'(start_value) + gcd_pkg::SUM_W'(job_count);
  end

  for (genvar i = 0; i < LEVELS - 1; i++) begin : g_lim
    always_ff @(posedge clk) begin
      lim[i] <= gcd_pkg::SUM_W'(start_value) + gcd_pkg::SUM_W'(job_count)
                - gcd_pkg::SUM_W'(job_count >> (i + 1));
    end
  end

  for (genvar i = 0; i < LEVELS; i++) begin : g_chunk
    always_ff @(posedge clk) begin
      chunk[i] <= gcd_pkg::chunk_of(profile, thread_count, i);
    end
  end

  assign ctl.busy    = (init_cnt != 2'd0);
  assign ctl.reload  = (init_cnt == 2'd1);
  assign ctl.start   = start_value;
  assign ctl.last    = last;
  assign ctl.workers = worker_count;

endmodule

FILE: hdl/gcd_step.sv
// Request register, grant logic with the job counter state, and reply register.
// Depends on gcd_pkg and the gcd_req_if / gcd_rsp_if channels.
module gcd_step #(
  parameter int LEVELS = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  gcd_pkg::cfg_ctl_t            ctl,
  input  logic [gcd_pkg::SUM_W-1:0]    lim [LEVELS-1],
  input  logic [gcd_pkg::CHUNK_W-1:0]  chunk [LEVELS],
  gcd_req_if.sink                      req,
  gcd_rsp_if.source                    rsp
);

  localparam int LVL_W = (LEVELS > 2) ? $clog2(LEVELS) : 1;
  localparam int LIM_W = (LEVELS > 2) ? $clog2(LEVELS - 1) : 1;
  localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(LEVELS - 1);

  logic                          s1_valid;
  logic [gcd_pkg::REQ_W-1:0]     s1_req;
  logic                          o_valid;
  logic                          advance;

  logic [gcd_pkg::JOB_W-1:0]     current_job;
  logic [LVL_W-1:0]              size_level;
  logic [gcd_pkg::WRK_W-1:0]     finished_replies;

  logic [gcd_pkg::CHUNK_W-1:0]   inc;
  logic [gcd_pkg::SUM_W-1:0]     next_sum;
  logic [gcd_pkg::SUM_W-1:0]     lim_sel;
  logic                          exhausted;
  logic                          level_up;
  logic [gcd_pkg::WRK_W-1:0]     finished_next;
  logic [LVL_W-1:0]              init_level;

  assign advance   = s1_valid && (!o_valid || rsp.ready);
  assign req.ready = !ctl.busy && (!s1_valid || advance);
  assign rsp.valid = o_valid;

  always_comb begin
    inc       = chunk[size_level];
    next_sum  = {1'b0, current_job} + gcd_pkg::SUM_W'(inc);
    exhausted = (next_sum >= ctl.last);
    lim_sel   = (size_level == TOP_LVL) ? '1 : lim[size_level[LIM_W-1:0]];
    level_up  = (size_level != TOP_LVL) && (next_sum >= lim_sel);
    finished_next = (exhausted && finished_replies != '1) ? finished_replies + 1'b1
                                                          : finished_replies;
  end

  // First level whose chunk still fits below its limit
  always_comb begin
    init_level = TOP_LVL;
    for (int i = LEVELS - 2; i >= 0; i--) begin
      if ({1'b0, ctl.start} + gcd_pkg::SUM_W'(chunk[i]) < lim[i]) begin
        init_level = LVL_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_req <= req.requester;
    end
    if (ctl.reload) begin
      current_job      <= ctl.start;
      size_level       <= init_level;
      finished_replies <= '0;
    end else if (advance) begin
      current_job      <= next_sum[gcd_pkg::JOB_W] ? gcd_pkg::JOB_MAX
                                                   : next_sum[gcd_pkg::JOB_W-1:0];
      size_level       <= level_up ? size_level + 1'b1 : size_level;
      finished_replies <= finished_next;
    end
    if (advance) begin
      rsp.destination     <= s1_req;
      rsp.first_job       <= current_job;
      rsp.chunk_size      <= inc;
      rsp.range_exhausted <= exhausted;
      rsp.all_done        <= (finished_next >= ctl.workers);
    end
  end

endmodule

FILE: hdl/guided_chunk_dispenser_top.sv
// Guided chunk dispenser: a request passes the request register, then the reply register;
// throughput one request per cycle while replies are taken and no reload holds requests off.
// Reset (synchronous, active high) loads register defaults; requests are held off
// after reset and after each write to the five registers while limits reload.
// A reply may wait in the output register while the next request is taken.
// Depends on gcd_pkg, gcd_if, gcd_cfg and gcd_step.
module guided_chunk_dispenser_top #(
  parameter int LEVELS = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gcd_pkg::ADDR_W-1:0]  paddr,
  input  logic [gcd_pkg::DATA_W-1:0]  pwdata,
  output logic [gcd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  gcd_req_if.sink                     req,
  gcd_rsp_if.source                   rsp
);

  // Control from the register block to the grant logic: busy holds off requests,
  // reload loads the job counter and the first level that fits.
  gcd_pkg::cfg_ctl_t            ctl;
  // Per-level limits (the top level has none) and chunk sizes, registered
  logic [gcd_pkg::SUM_W-1:0]    lim [LEVELS-1];
  logic [gcd_pkg::CHUNK_W-1:0]  chunk [LEVELS];

  gcd_cfg #(
    .LEVELS (LEVELS)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ctl     (ctl),
    .lim     (lim),
    .chunk   (chunk)
  );

  // Grant path: request register, one add against the level's limit and the
  // last value, then the reply register. The counter advances as a request
  // moves into the reply register, so back-to-back requests see fresh state.
  gcd_step #(
    .LEVELS (LEVELS)
  ) u_step (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .lim   (lim),
    .chunk (chunk),
    .req   (req),
    .rsp   (rsp)
  );

endmodule

FILE: hdl/gcd_checker.sv
// Port-level checks of the guided chunk dispenser, bound to the top level.
// Depends on gcd_pkg.
module gcd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [gcd_pkg::ADDR_W-1:0]  paddr,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [gcd_pkg::JOB_W-1:0]   rsp_first_job,
  input logic [gcd_pkg::CHUNK_W-1:0] rsp_chunk_size
);

  // A stalled reply holds its job range
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_first_job)
                                && $stable(rsp_chunk_size))
    else $error("reply changed while stalled");

  // Every grant covers at least one job
  a_chunk_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_chunk_size != '0)
    else $error("zero chunk granted");

  // No request is taken in the first cycle out of reset
  a_reset_hold: assert property (@(posedge clk)
    $fell(rst) |-> !req_ready)
    else $error("request taken before state load");

  // A write to one of the five registers holds off requests while limits reload
  a_cfg_hold: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && paddr[gcd_pkg::ADDR_W-1:2] <= gcd_pkg::REG_WORKERS
    |=> !req_ready ##1 !req_ready)
    else $error("request taken during reload");

endmodule

bind guided_chunk_dispenser_top gcd_checker u_gcd_checker (
  .clk            (clk),
  .rst            (rst),
  .psel           (psel),
  .penable        (penable),
  .pwrite         (pwrite),
  .paddr          (paddr),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_first_job  (rsp.first_job),
  .rsp_chunk_size (rsp.chunk_size)
);
